// ===== sv/qcar_pkg.sv =====
// shared constants and codes for the per-channel requantizer
package qcar_pkg;

   localparam int MAX_CHANNELS_DEFAULT = 1024;
   localparam int FRAC_BITS_DEFAULT    = 16;

   localparam int CHANNEL_W = 10;
   localparam int SAMPLE_W  = 8;
   localparam int COEF_W    = 32;
   localparam int ZP_W      = 8;
   localparam int RESULT_W  = 8;

   localparam int REQ_FIELDS_W = CHANNEL_W + SAMPLE_W + 2 * COEF_W;
   localparam int REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W  = RESULT_W;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = ZP_W;

   // difference of a sample and the input zero point, product and accumulated value
   localparam int DIFF_W = SAMPLE_W + 1;
   localparam int PROD_W = COEF_W + DIFF_W;
   localparam int ACC_W  = PROD_W + 1;

   // widened channel index width, used for the range check against MAX_CHANNELS
   localparam int CHAN_EXT_W = 17;

   typedef enum logic {
      OP_LOAD    = 1'b0,
      OP_PROCESS = 1'b1
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IN_ZERO_POINT  = 1'b0,
      CSR_OUT_ZERO_POINT = 1'b1
   } csr_index_type;

endpackage

// ===== sv/quantized_channel_affine_requant.sv =====
// Per-channel quantized batch-norm requantizer. A load request stores a channel's gain and
// bias; a process request returns round_even(gain*(sample-in_zp)+bias)+out_zp clamped to
// 0..255 together with a saturation flag. One request is taken every cycle while the result
// port does not stall. A process request's result is registered after the parameter table
// read, after the multiply-accumulate and after rounding and clamping. Ready follows the
// result port back through the pipeline, so empty stages keep taking requests while a
// result waits. The table holds no reset value, so no clearing pass is needed, and a
// channel that was never loaded returns an undefined result.
module quantized_channel_affine_requant
   import qcar_pkg::*;
#(
   parameter int MAX_CHANNELS = MAX_CHANNELS_DEFAULT,
   parameter int FRAC_BITS    = FRAC_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // channel[9:0], sample[17:10], multiplier[49:18], offset[81:50], zero pad[87:82]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // operation[0]
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // result[7:0]
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // saturated[0]
   output logic                   rsp_tuser
);

   localparam int ADDR_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int QW     = ACC_W - FRAC_BITS + 1;
   localparam int SUM_W  = QW + 1;

   // request fields
   logic [CHANNEL_W-1:0]  req_channel;
   logic [SAMPLE_W-1:0]   req_sample;
   logic [COEF_W-1:0]     req_multiplier;
   logic [COEF_W-1:0]     req_offset;
   op_type                req_op;
   logic [CHAN_EXT_W-1:0] chan_ext;
   logic [ADDR_W-1:0]     addr;
   logic                  in_range;
   logic                  req_acc;

   assign req_channel    = req_tdata[CHANNEL_W-1:0];
   assign req_sample     = req_tdata[CHANNEL_W +: SAMPLE_W];
   assign req_multiplier = req_tdata[CHANNEL_W+SAMPLE_W +: COEF_W];
   assign req_offset     = req_tdata[CHANNEL_W+SAMPLE_W+COEF_W +: COEF_W];
   assign req_op         = op_type'(req_tuser);
   assign chan_ext       = CHAN_EXT_W'(req_channel);
   assign addr           = chan_ext[ADDR_W-1:0];
   assign in_range       = chan_ext < CHAN_EXT_W'(MAX_CHANNELS);

   // configuration
   logic [ZP_W-1:0] in_zp_ff, in_zp_in;
   logic [ZP_W-1:0] out_zp_ff, out_zp_in;

   always_comb begin
      in_zp_in  = in_zp_ff;
      out_zp_in = out_zp_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_IN_ZERO_POINT:  in_zp_in  = csr_wdata;
            CSR_OUT_ZERO_POINT: out_zp_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // pipeline flow control
   logic v1_ff, v1_in;
   logic v2_ff, v2_in;
   logic v3_ff, v3_in;
   logic adv1, adv2, adv3;

   assign adv3       = !v3_ff || rsp_tready;
   assign adv2       = !v2_ff || adv3;
   assign adv1       = !v1_ff || adv2;
   assign req_tready = adv1;
   assign req_acc    = req_tvalid && req_tready;

   // parameter table
   logic [COEF_W-1:0] gain_mem [MAX_CHANNELS];
   logic [COEF_W-1:0] bias_mem [MAX_CHANNELS];
   logic [COEF_W-1:0] gain1_ff;
   logic [COEF_W-1:0] bias1_ff;

   always_ff @(posedge clock) begin
      if (req_acc && req_op == OP_LOAD && in_range) begin
         gain_mem[addr] <= req_multiplier;
         bias_mem[addr] <= req_offset;
      end
      if (adv1) begin
         gain1_ff <= gain_mem[addr];
         bias1_ff <= bias_mem[addr];
      end
   end

   // stage 1: sample offset
   logic signed [DIFF_W-1:0] diff1_ff, diff1_in;
   logic                     inr1_ff, inr1_in;

   assign v1_in    = adv1 ? (req_acc && req_op == OP_PROCESS) : v1_ff;
   assign diff1_in = adv1 ? $signed({1'b0, req_sample} - {1'b0, in_zp_ff}) : diff1_ff;
   assign inr1_in  = adv1 ? in_range : inr1_ff;

   // stage 2: multiply-accumulate
   logic signed [COEF_W-1:0] gain_eff, bias_eff;
   logic signed [PROD_W-1:0] prod;
   logic signed [ACC_W-1:0]  acc2_ff, acc2_in;

   assign gain_eff = inr1_ff ? $signed(gain1_ff) : '0;
   assign bias_eff = inr1_ff ? $signed(bias1_ff) : '0;
   assign prod     = gain_eff * diff1_ff;
   assign v2_in    = adv2 ? v1_ff : v2_ff;
   assign acc2_in  = adv2 ? (ACC_W'(prod) + ACC_W'(bias_eff)) : acc2_ff;

   // stage 3: round half to even, add zero point, clamp
   logic signed [QW-1:0]    q_trunc, q_rnd;
   logic [FRAC_BITS-1:0]    frac;
   logic                    frac_half, frac_low, round_up;
   logic signed [SUM_W-1:0] q_sum;
   logic                    sat_low, sat_high;
   logic [RESULT_W-1:0]     res3_ff, res3_in;
   logic                    sat3_ff, sat3_in;

   assign q_trunc   = $signed({acc2_ff[ACC_W-1], acc2_ff[ACC_W-1:FRAC_BITS]});
   assign frac      = acc2_ff[FRAC_BITS-1:0];
   assign frac_half = frac[FRAC_BITS-1];
   assign frac_low  = |frac[FRAC_BITS-2:0];
   assign round_up  = frac_half && (frac_low || q_trunc[0]);
   assign q_rnd     = q_trunc + $signed(QW'(round_up));
   assign q_sum     = SUM_W'(q_rnd) + $signed({{(SUM_W-ZP_W){1'b0}}, out_zp_ff});
   assign sat_low   = q_sum[SUM_W-1];
   assign sat_high  = !sat_low && (q_sum > $signed(SUM_W'(2**RESULT_W - 1)));

   always_comb begin
      v3_in   = adv3 ? v2_ff : v3_ff;
      res3_in = res3_ff;
      sat3_in = sat3_ff;
      if (adv3) begin
         sat3_in = sat_low || sat_high;
         priority if (sat_low) begin
            res3_in = '0;
         end else if (sat_high) begin
            res3_in = '1;
         end else begin
            res3_in = q_sum[RESULT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_zp_ff  <= '0;
         out_zp_ff <= '0;
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         v3_ff     <= 1'b0;
      end else begin
         in_zp_ff  <= in_zp_in;
         out_zp_ff <= out_zp_in;
         v1_ff     <= v1_in;
         v2_ff     <= v2_in;
         v3_ff     <= v3_in;
      end
      diff1_ff <= diff1_in;
      inr1_ff  <= inr1_in;
      acc2_ff  <= acc2_in;
      res3_ff  <= res3_in;
      sat3_ff  <= sat3_in;
   end

   assign rsp_tvalid = v3_ff;
   assign rsp_tdata  = res3_ff;
   assign rsp_tuser  = sat3_ff;

   // a saturated result sits on one of the rails
   a_sat_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> (rsp_tdata == '0 || rsp_tdata == '1))
      else $error("saturated result not at a rail");

   // load requests never enter the arithmetic stages
   a_load_no_rsp: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_op == OP_LOAD |=> !v1_ff)
      else $error("load request produced a pipeline entry");

   // a stalled stage keeps its request
   a_stage1_hold: assert property (@(posedge clock) disable iff (reset)
      v1_ff && !adv2 |=> v1_ff && $stable(acc2_ff) && v2_ff)
      else $error("stalled request lost in stage one");

   // pipeline is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !v1_ff && !v2_ff && !v3_ff)
      else $error("pipeline not empty after reset");

endmodule
